/* design/ufhp_pkg.sv */
package ufhp_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned OffsetW = 7;
  localparam int unsigned IhlW    = 4;

  // Byte positions of the fixed header fields within the frame.
  localparam logic [WordW-1:0] EtherHiIdx  = 16'd12;
  localparam logic [WordW-1:0] EtherLoIdx  = 16'd13;
  localparam logic [WordW-1:0] VerIhlIdx   = 16'd14;
  localparam logic [WordW-1:0] ProtocolIdx = 16'd23;

  // Header sizes in bytes.
  localparam logic [OffsetW-1:0] EthHdrBytes = 7'd14;
  localparam logic [OffsetW-1:0] UdpHdrBytes = 7'd8;
  localparam logic [WordW-1:0]   MinIpv4Len  = 16'd34;
  localparam logic [WordW-1:0]   UdpHdrLen   = 16'd8;

  // Byte positions within the UDP header.
  localparam logic [2:0] UdpSrcHi = 3'd0;
  localparam logic [2:0] UdpSrcLo = 3'd1;
  localparam logic [2:0] UdpDstHi = 3'd2;
  localparam logic [2:0] UdpDstLo = 3'd3;
  localparam logic [2:0] UdpLenHi = 3'd4;
  localparam logic [2:0] UdpLenLo = 3'd5;

  // Protocol codes.
  localparam logic [WordW-1:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [IhlW-1:0]  IpVersion4    = 4'd4;
  localparam logic [IhlW-1:0]  IhlMin        = 4'd5;
  localparam logic [ByteW-1:0] ProtoUdp      = 8'd17;
  localparam logic [WordW-1:0] DhcpServer    = 16'd67;
  localparam logic [WordW-1:0] DhcpClient    = 16'd68;

  localparam logic [WordW-1:0] CountMax = 16'hFFFF;

endpackage

/* design/ufhp_in_if.sv */
interface ufhp_in_if
  import ufhp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/ufhp_out_if.sv */
interface ufhp_out_if
  import ufhp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               is_udp;
  logic               is_dhcp;
  logic [WordW-1:0]   source_port;
  logic [WordW-1:0]   destination_port;
  logic [OffsetW-1:0] payload_offset;
  logic [WordW-1:0]   payload_length;

  modport source (
    output valid, output is_udp, output is_dhcp, output source_port,
    output destination_port, output payload_offset, output payload_length,
    input ready
  );
  modport sink (
    input valid, input is_udp, input is_dhcp, input source_port,
    input destination_port, input payload_offset, input payload_length,
    output ready
  );
endinterface

/* design/udp_frame_header_parser_core.sv */
// Parses the headers of an Ethernet frame that arrives one byte per transaction
// on in_i, with last_byte set on the final byte. For every frame it delivers one
// transaction on out_o: is_udp is set for a well-formed IPv4/UDP frame long enough
// to hold its IP and UDP headers, and then the ports, the payload offset, the
// payload length (the smaller of the UDP length minus 8 and the bytes actually
// present after the UDP header) and a DHCP flag for port 67 or 68 are filled in;
// otherwise every other field is zero. The block accepts one byte every cycle
// with no gaps between frames, unless a final byte must wait for the result
// register to be taken. Each byte passes an input register and then one update
// of the header capture registers; a final byte then loads the result register,
// which drives out_o. One finished result can wait in the output register while
// the next frame streams in; only a second final byte stalls behind it.
// Frame lengths above 65535 bytes are counted as 65535.
module udp_frame_header_parser_core
  import ufhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ufhp_in_if.sink    in_i,
  ufhp_out_if.source out_o
);

  // Input register stage.
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;

  // Header capture state for the frame in progress.
  logic [WordW-1:0] cnt_q, cnt_d;
  logic [WordW-1:0] ether_q, ether_d;
  logic [ByteW-1:0] verlen_q, verlen_d;
  logic [ByteW-1:0] proto_q, proto_d;
  logic [WordW-1:0] sport_q, sport_d;
  logic [WordW-1:0] dport_q, dport_d;
  logic [WordW-1:0] ulen_q, ulen_d;

  // Result register.
  logic               res_valid_q;
  logic               res_udp_q, res_udp_d;
  logic               res_dhcp_q, res_dhcp_d;
  logic [WordW-1:0]   res_sport_q, res_sport_d;
  logic [WordW-1:0]   res_dport_q, res_dport_d;
  logic [OffsetW-1:0] res_off_q, res_off_d;
  logic [WordW-1:0]   res_plen_q, res_plen_d;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  // Handshake: a non-final byte never needs the result register.
  assign out_free = !res_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // Where the UDP header sits, from the IHL seen so far.
  logic [WordW-1:0]   idx;
  logic [IhlW-1:0]    ihl_old;
  logic [OffsetW-1:0] udp_at;
  logic [WordW-1:0]   udp_rel;
  logic               udp_hit;

  assign idx     = cnt_q;
  assign ihl_old = verlen_q[IhlW-1:0];
  assign udp_at  = EthHdrBytes + {1'b0, ihl_old, 2'b00};
  assign udp_rel = idx - {{(WordW-OffsetW){1'b0}}, udp_at};
  assign udp_hit = (idx > VerIhlIdx) && (idx >= {{(WordW-OffsetW){1'b0}}, udp_at})
                && (udp_rel < 16'd6);

  // Capture the header fields carried by the current byte.
  always_comb begin
    ether_d  = ether_q;
    verlen_d = verlen_q;
    proto_d  = proto_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    ulen_d   = ulen_q;
    if (idx == EtherHiIdx) begin
      ether_d[15:8] = s1_byte_q;
    end else if (idx == EtherLoIdx) begin
      ether_d[7:0] = s1_byte_q;
    end else if (idx == VerIhlIdx) begin
      verlen_d = s1_byte_q;
    end else if (idx == ProtocolIdx) begin
      proto_d = s1_byte_q;
    end
    if (udp_hit) begin
      unique case (udp_rel[2:0])
        UdpSrcHi: sport_d[15:8] = s1_byte_q;
        UdpSrcLo: sport_d[7:0]  = s1_byte_q;
        UdpDstHi: dport_d[15:8] = s1_byte_q;
        UdpDstLo: dport_d[7:0]  = s1_byte_q;
        UdpLenHi: ulen_d[15:8]  = s1_byte_q;
        UdpLenLo: ulen_d[7:0]   = s1_byte_q;
        default: ;
      endcase
    end
    cnt_d = (cnt_q != CountMax) ? cnt_q + 16'd1 : cnt_q;
  end

  // Frame verdict and payload fields, from the state including the final byte.
  logic [OffsetW-1:0] pay_at;
  logic [WordW-1:0]   avail;
  logic [WordW-1:0]   by_hdr;
  logic               udp_ok;

  assign pay_at = udp_at + UdpHdrBytes;
  assign avail  = cnt_d - {{(WordW-OffsetW){1'b0}}, pay_at};
  assign by_hdr = (ulen_d >= UdpHdrLen) ? ulen_d - UdpHdrLen : '0;
  assign udp_ok = (ether_d == EtherTypeIpv4) && (cnt_d >= MinIpv4Len)
               && (verlen_d[ByteW-1:IhlW] == IpVersion4) && (ihl_old >= IhlMin)
               && (proto_d == ProtoUdp)
               && (cnt_d >= {{(WordW-OffsetW){1'b0}}, pay_at});

  always_comb begin
    res_udp_d   = udp_ok;
    res_dhcp_d  = 1'b0;
    res_sport_d = '0;
    res_dport_d = '0;
    res_off_d   = '0;
    res_plen_d  = '0;
    if (udp_ok) begin
      res_sport_d = sport_d;
      res_dport_d = dport_d;
      res_off_d   = pay_at;
      res_plen_d  = (by_hdr < avail) ? by_hdr : avail;
      res_dhcp_d  = (sport_d == DhcpServer) || (sport_d == DhcpClient)
                 || (dport_d == DhcpServer) || (dport_d == DhcpClient);
    end
  end

  // State update; the final byte returns everything to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ether_q  <= '0;
      verlen_q <= '0;
      proto_q  <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
      ulen_q   <= '0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        cnt_q    <= '0;
        ether_q  <= '0;
        verlen_q <= '0;
        proto_q  <= '0;
        sport_q  <= '0;
        dport_q  <= '0;
        ulen_q   <= '0;
      end else begin
        cnt_q    <= cnt_d;
        ether_q  <= ether_d;
        verlen_q <= verlen_d;
        proto_q  <= proto_d;
        sport_q  <= sport_d;
        dport_q  <= dport_d;
        ulen_q   <= ulen_d;
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_udp_q   <= res_udp_d;
      res_dhcp_q  <= res_dhcp_d;
      res_sport_q <= res_sport_d;
      res_dport_q <= res_dport_d;
      res_off_q   <= res_off_d;
      res_plen_q  <= res_plen_d;
    end
  end

  assign out_o.valid            = res_valid_q;
  assign out_o.is_udp           = res_udp_q;
  assign out_o.is_dhcp          = res_dhcp_q;
  assign out_o.source_port      = res_sport_q;
  assign out_o.destination_port = res_dport_q;
  assign out_o.payload_offset   = res_off_q;
  assign out_o.payload_length   = res_plen_q;

  // A DHCP result is always a UDP result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_dhcp_q |-> res_udp_q)
    else $error("DHCP flag set on a non-UDP result");

  // Non-UDP results carry zero in every other field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_udp_q |-> (res_sport_q == '0) && (res_dport_q == '0)
                                  && (res_off_q == '0) && (res_plen_q == '0))
    else $error("non-UDP result carries nonzero fields");

  // The frame state is cleared after each final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> (cnt_q == '0) && (verlen_q == '0) && (ulen_q == '0))
    else $error("frame state not cleared after final byte");

  // With the result register empty, the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> in_i.ready)
    else $error("input stalled while result register is empty");

  // A UDP result always points past the shortest IPv4 and UDP headers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_udp_q |-> res_off_q >= 7'd42)
    else $error("UDP payload offset too small");

endmodule
